// ===== design/assert_macros.svh =====
// Assertion macros shared by the checksum block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante. Uses clk and arst_n from the enclosing scope.
`define CRC32M_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("crc32m assertion failed");

// Check that cons holds in the cycle after ante.
`define CRC32M_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("crc32m assertion failed");

`endif

// ===== design/crc32m_pkg.sv =====
// Constants shared by the masked CRC-32 byte stream block.
`timescale 1ns / 1ps
package crc32m_pkg;

	localparam int unsigned CRC_W      = 32;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned CRC_ROUNDS = 8;

	// Reflected CRC-32 polynomial.
	localparam logic [CRC_W-1:0] REFLECTED_POLY = 32'hEDB8_8320;
	// Mask applied to the running value after every byte.
	localparam logic [CRC_W-1:0] CRC_XOR_MASK   = 32'hD202_EF8D;
	localparam logic [CRC_W-1:0] CRC_SEED       = '0;

	typedef logic [CRC_W-1:0]  crc_t;
	typedef logic [BYTE_W-1:0] byte_t;

endpackage

// ===== design/crc32m_if.sv =====
// Valid/ready channel interfaces for message bytes and checksum results.
`timescale 1ns / 1ps
interface crc32m_byte_if;
	logic                 valid;
	logic                 ready;
	crc32m_pkg::byte_t    data_byte;
	logic                 first_byte;
	logic                 last_byte;

	modport source(output valid, data_byte, first_byte, last_byte, input ready);
	modport sink(input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface crc32m_sum_if;
	logic                 valid;
	logic                 ready;
	crc32m_pkg::crc_t     checksum;
	logic                 is_final;

	modport source(output valid, checksum, is_final, input ready);
	modport sink(input valid, checksum, is_final, output ready);
endinterface

// ===== design/crc32m_fold.sv =====
// Combinational fold of one byte into the running checksum, with restart and mask.
`timescale 1ns / 1ps
module crc32m_fold (
	input  crc32m_pkg::crc_t  crc_in,
	input  crc32m_pkg::byte_t data_byte,
	input  logic              restart,
	output crc32m_pkg::crc_t  crc_out
);

	always_comb begin
		crc32m_pkg::crc_t r;
		r = restart ? crc32m_pkg::CRC_SEED : crc_in;
		r = r ^ {{(crc32m_pkg::CRC_W - crc32m_pkg::BYTE_W){1'b0}}, data_byte};
		// Eight shift-and-xor rounds, one per data bit, LSB first.
		for (int k = 0; k < crc32m_pkg::CRC_ROUNDS; k++) begin
			if (r[0]) begin
				r = (r >> 1) ^ crc32m_pkg::REFLECTED_POLY;
			end else begin
				r = r >> 1;
			end
		end
		crc_out = r ^ crc32m_pkg::CRC_XOR_MASK;
	end

endmodule

// ===== design/crc32_masked_byte_stream.sv =====
// Top level: running masked CRC-32 over a valid/ready byte stream.
// Each result passes the input register, the eight-round fold and the result register;
// a stall on the result side holds its byte in the input register.
// Throughput: one byte per cycle while the receiver keeps ready high.
// Reset (arst_n low, asynchronous): both stages empty and the running checksum cleared to zero.
// A byte without a first mark continues from the running checksum, also across messages.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module crc32_masked_byte_stream (
	input  logic                  clk,
	input  logic                  arst_n,
	crc32m_byte_if.sink           msg,
	crc32m_sum_if.source          sums
);

	// Input stage: holds one accepted transaction until the result register can take it.
	logic              valid_s1;
	crc32m_pkg::byte_t data_s1;
	logic              first_s1;
	logic              last_s1;

	// Result stage and the running checksum that the next byte folds into.
	logic              out_valid_q;
	crc32m_pkg::crc_t  checksum_q;
	logic              is_final_q;
	crc32m_pkg::crc_t  crc_q;

	crc32m_pkg::crc_t  crc_next;
	logic              advance;

	// The held byte moves on whenever the result register is empty or is being read.
	// Because the running checksum is updated at that same edge, the next byte always
	// sees the value left by the previous one, so bytes may follow back to back.
	assign advance   = valid_s1 && (!out_valid_q || sums.ready);
	assign msg.ready = !valid_s1 || advance;

	crc32m_fold u_fold (
		.crc_in    (crc_q),
		.data_byte (data_s1),
		.restart   (first_s1),
		.crc_out   (crc_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (msg.ready) begin
			valid_s1 <= msg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (msg.valid && msg.ready) begin
			data_s1  <= msg.data_byte;
			first_s1 <= msg.first_byte;
			last_s1  <= msg.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			crc_q       <= crc32m_pkg::CRC_SEED;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				crc_q       <= crc_next;
			end else if (sums.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			checksum_q <= crc_next;
			is_final_q <= last_s1;
		end
	end

	assign sums.valid    = out_valid_q;
	assign sums.checksum = checksum_q;
	assign sums.is_final = is_final_q;

	// The running checksum always matches the result that was just produced.
	`CRC32M_ASSERT_NEXT(a_crc_tracks_result, advance, crc_q == checksum_q)
	// Moving a byte forward always leaves a result to deliver.
	`CRC32M_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_q)
	// A held byte that cannot move on blocks new input.
	`CRC32M_ASSERT_NOW(a_full_blocks_input, valid_s1 && !advance, !msg.ready)
	// A held byte that cannot move on keeps its contents.
	`CRC32M_ASSERT_NEXT(a_held_byte_stable, valid_s1 && !advance,
		valid_s1 && data_s1 == $past(data_s1) && first_s1 == $past(first_s1))

endmodule

// ===== tb/crc32_masked_byte_stream_tb.sv =====
// Self-checking testbench for the masked CRC-32 byte stream block.
`timescale 1ns / 1ps
module crc32_masked_byte_stream_tb;

	// The predictor keeps its own copy of the polynomial and the mask, so a wrong
	// package constant shows up as a mismatch instead of being copied.
	localparam logic [31:0] FOLD_POLY = 32'hEDB8_8320;
	localparam logic [31:0] SUM_MASK  = 32'hD202_EF8D;

	// Minimum number of input transactions in the whole run, directed part included.
	localparam int BYTE_COUNT   = 1850;
	// Cycles the receiver holds ready low during a long output stall.
	localparam int HOLD_OFF     = 64;
	// Results after which a long output stall begins.
	localparam int HOLD_AT_A    = 400;
	localparam int HOLD_AT_B    = 1300;
	// Extra cycles after the last expected result.
	localparam int DRAIN_CYCLES = 10;
	// Cycles without any transaction before the run is declared hung. The longest
	// correct quiet stretch is the long stall plus a few idle cycles on each side.
	localparam int QUIET_LIMIT  = 1000;
	// Cap on printed mismatch lines so that a badly broken block does not flood the log.
	localparam int REPORT_CAP   = 100;

	typedef struct packed {
		crc32m_pkg::crc_t checksum;
		logic             is_final;
	} sum_rec_t;

	// Tracks the running checksum of the byte stream and the sums still owed by the block.
	class masked_crc_tracker;
		crc32m_pkg::crc_t running;
		sum_rec_t         pending_sums[$];
		int               mismatches;
		int               sums_checked;
		int               finals_seen;
		int               reports;

		function new();
			running      = '0;
			mismatches   = 0;
			sums_checked = 0;
			finals_seen  = 0;
			reports      = 0;
		endfunction

		// Reflected CRC-32 step, one bit per round, LSB first.
		function crc32m_pkg::crc_t fold(crc32m_pkg::crc_t acc, crc32m_pkg::byte_t b);
			crc32m_pkg::crc_t r;
			r = acc ^ {24'h0, b};
			for (int k = 0; k < 8; k++) begin
				if (r[0]) begin
					r = (r >> 1) ^ FOLD_POLY;
				end else begin
					r = r >> 1;
				end
			end
			return r;
		endfunction

		function void flag(string what, logic [31:0] want, logic [31:0] got);
			mismatches++;
			if (reports < REPORT_CAP) begin
				reports++;
				$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
			end
		endfunction

		// Called for every accepted byte; a first mark restarts from zero, otherwise
		// the byte continues from the previous value, even across a last mark.
		function void absorb_byte(crc32m_pkg::byte_t b, logic first_mark, logic last_mark);
			sum_rec_t rec;
			running      = fold(first_mark ? crc32m_pkg::crc_t'(0) : running, b) ^ SUM_MASK;
			rec.checksum = running;
			rec.is_final = last_mark;
			pending_sums.push_back(rec);
		endfunction

		// Called for every accepted result; compares it with the oldest expectation.
		function void compare_sum(crc32m_pkg::crc_t got_sum, logic got_final);
			sum_rec_t want;
			if (pending_sums.size() == 0) begin
				mismatches++;
				if (reports < REPORT_CAP) begin
					reports++;
					$display("%0t: unexpected result, expected none, actual checksum %h is_final %b",
						$time, got_sum, got_final);
				end
				return;
			end
			want = pending_sums.pop_front();
			sums_checked++;
			if (got_final === 1'b1) begin
				finals_seen++;
			end
			if (got_sum !== want.checksum) begin
				flag("checksum", want.checksum, got_sum);
			end
			if (got_final !== want.is_final) begin
				flag("is_final", {31'h0, want.is_final}, {31'h0, got_final});
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	crc32m_byte_if msg_ch();
	crc32m_sum_if  sum_ch();

	crc32_masked_byte_stream dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.sums   (sum_ch)
	);

	masked_crc_tracker tracker = new();

	// When steady is set, neither side adds random idle gaps, so back-to-back transactions occur.
	bit steady;
	int bytes_sent;
	int messages_sent;
	int sums_taken;
	int long_holds;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Sends one byte. It is entered at a falling edge and returns at the falling edge
	// after the transaction, so valid stays high between back-to-back bytes with a
	// single assignment per time step.
	task automatic send_byte(input crc32m_pkg::byte_t b, input logic first_mark,
			input logic last_mark);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			msg_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		msg_ch.valid      <= 1'b1;
		msg_ch.data_byte  <= b;
		msg_ch.first_byte <= first_mark;
		msg_ch.last_byte  <= last_mark;
		do @(posedge clk); while (msg_ch.ready !== 1'b1);
		tracker.absorb_byte(b, first_mark, last_mark);
		bytes_sent++;
		if (last_mark) begin
			messages_sent++;
		end
		@(negedge clk);
	endtask

	// Message content leans on the extremes now and then so that all-zero and
	// all-one bytes keep appearing in the middle of messages.
	function automatic crc32m_pkg::byte_t pick_byte();
		int sel;
		sel = $urandom_range(0, 7);
		if (sel == 0) begin
			return 8'h00;
		end else if (sel == 1) begin
			return 8'hFF;
		end
		return crc32m_pkg::byte_t'($urandom_range(0, 255));
	endfunction

	// Receiver. It stalls a random number of cycles before each result and, twice in
	// the run, holds ready low for a long stretch while the sender keeps offering
	// bytes, so the block fills up and has to push back on its input.
	initial begin
		int stall;
		sum_ch.ready = 1'b0;
		sums_taken   = 0;
		long_holds   = 0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 5);
			if (sums_taken == HOLD_AT_A || sums_taken == HOLD_AT_B) begin
				stall = HOLD_OFF;
				long_holds++;
			end
			if (stall > 0) begin
				sum_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			sum_ch.ready <= 1'b1;
			do @(posedge clk); while (sum_ch.valid !== 1'b1);
			tracker.compare_sum(sum_ch.checksum, sum_ch.is_final);
			sums_taken++;
			@(negedge clk);
		end
	end

	// Watchdog: any transaction on either channel resets the quiet count.
	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((msg_ch.valid === 1'b1 && msg_ch.ready === 1'b1) ||
					(sum_ch.valid === 1'b1 && sum_ch.ready === 1'b1)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("Timeout: no transaction for %0d cycles, %0d results still owed",
			QUIET_LIMIT, tracker.pending_sums.size());
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int kind;
		int len;
		// The "123456789" check string, sent as one message.
		crc32m_pkg::byte_t check_str[9];

		check_str = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};

		// Every input is known from time zero.
		arst_n            = 1'b0;
		msg_ch.valid      = 1'b0;
		msg_ch.data_byte  = '0;
		msg_ch.first_byte = 1'b0;
		msg_ch.last_byte  = 1'b0;
		steady            = 1'b0;
		bytes_sent        = 0;
		messages_sent     = 0;

		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part. The first bytes carry no first mark: right after reset the
		// block must continue from a zero checksum, and after a last mark it must keep
		// folding into the finished value instead of restarting on its own.
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b1);
		send_byte(8'hA5, 1'b0, 1'b0);
		send_byte(8'h5A, 1'b0, 1'b1);

		// One-byte messages, first and last mark together, on the extremes of the byte.
		send_byte(8'h00, 1'b1, 1'b1);
		send_byte(8'hFF, 1'b1, 1'b1);
		send_byte(8'h80, 1'b1, 1'b1);
		send_byte(8'h01, 1'b1, 1'b1);

		// A familiar nine-byte string, then a run of all-ones bytes with no idling.
		foreach (check_str[i]) begin
			send_byte(check_str[i], i == 0, i == 8);
		end
		steady = 1'b1;
		for (int i = 0; i < 4; i++) begin
			send_byte(8'hFF, i == 0, i == 3);
		end
		steady = 1'b0;

		// Random part. Most of it is well-formed messages with random content; the
		// rest continues without a first mark or carries random marks on every byte.
		while (bytes_sent < BYTE_COUNT) begin
			kind   = $urandom_range(0, 9);
			steady = ($urandom_range(0, 5) == 0);
			len    = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			if (kind < 8) begin
				for (int i = 0; i < len; i++) begin
					send_byte(pick_byte(), i == 0, i == len - 1);
				end
			end else if (kind == 8) begin
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++) begin
					send_byte(pick_byte(), 1'b0, i == len - 1);
				end
			end else begin
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++) begin
					send_byte(pick_byte(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end
			end
		end
		steady = 1'b0;
		msg_ch.valid <= 1'b0;

		// Wait for the last results; the watchdog bounds this loop.
		while (tracker.pending_sums.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d bytes (%0d ending in a last mark) and %0d checked sums,",
			bytes_sent, messages_sent, tracker.sums_checked);
		$display("with %0d final sums, %0d long output stalls and %0d mismatches.",
			tracker.finals_seen, long_holds, tracker.mismatches);
		if (tracker.mismatches == 0 && tracker.pending_sums.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/crc32m_pkg.sv
design/crc32m_if.sv
design/crc32m_fold.sv
design/crc32_masked_byte_stream.sv
tb/crc32_masked_byte_stream_tb.sv
